@@ rtl/hbrs_pkg.sv @@
package hbrs_pkg;

  localparam int unsigned DEF_CHUNK_SIZE = 8;
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned MAX_PLANES     = 8;

  localparam int unsigned NP_W   = 4;
  localparam int unsigned AL_W   = 3;
  localparam int unsigned CW_W   = 13;
  localparam int unsigned MINP_W = 16;
  localparam int unsigned BPE_W  = 3;

  localparam int unsigned CW_MAX    = (1 << CW_W) - 1;
  localparam int unsigned LINES_MAX = 5;
  localparam int unsigned PLANES_EFF_MAX = (MAX_PLANES < 8) ? MAX_PLANES : 8;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ELAP_W   = 32;
  localparam int unsigned PER_W    = 32;
  localparam int unsigned PLANE_W  = 3;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned OFF_W    = 23;
  localparam int unsigned FRM_W    = 32;
  localparam int unsigned IDX_W    = PLANE_W + ROW_W + 1;
  localparam int unsigned FACC_W   = PER_W + 3;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [NP_W-1:0]   DEF_NUM_PLANES = 4'd4;
  localparam logic [AL_W-1:0]   DEF_ADDR_LINES = 3'd4;
  localparam logic [CW_W-1:0]   DEF_CHAIN      = 13'd64;
  localparam logic [MINP_W-1:0] DEF_MIN_PERIOD = 16'd100;
  localparam logic              DEF_DBUF       = 1'b0;
  localparam logic [BPE_W-1:0]  DEF_BPE        = 3'd1;

  localparam logic [PLANE_W-1:0] RST_PLANE = PLANE_W'(DEF_NUM_PLANES - 4'd1);
  localparam logic [ROW_W-1:0]   RST_ROW   = ROW_W'((1 << DEF_ADDR_LINES) - 1);
  localparam logic [ROW_W-1:0]   RST_LAST  = ROW_W'((1 << DEF_ADDR_LINES) - 2);
  localparam logic [PER_W-1:0]   RST_BASE  = PER_W'(5 * DEF_CHAIN);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_SWAP    = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_RESTART = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_PLANES = 3'd0,
    CFG_ADDR_LINES = 3'd1,
    CFG_CHAIN      = 3'd2,
    CFG_MIN_PERIOD = 3'd3,
    CFG_DBUF       = 3'd4,
    CFG_BPE        = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]         pad;
    logic               swap_waiting;
    logic [FRM_W-1:0]   frames;
    logic               shown_buffer;
    logic [ROW_W-1:0]   addr_toggle;
    logic [ROW_W-1:0]   addr_lines;
    logic [OFF_W-1:0]   byte_offset;
    logic [ROW_W-1:0]   load_row;
    logic [PLANE_W-1:0] load_plane;
    logic [PER_W-1:0]   next_period;
  } res_t;

endpackage

@@ rtl/hbrs_mul.sv @@
module hbrs_mul #(
  parameter int unsigned A_W = 13,
  parameter int unsigned B_W = 9
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q, p_d;

  assign p_d = (A_W + B_W)'(a_i) * (A_W + B_W)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/hbrs_colpad.sv @@
module hbrs_colpad #(
  parameter int unsigned CHUNK_SIZE = hbrs_pkg::DEF_CHUNK_SIZE,
  parameter int unsigned MAX_WIDTH  = hbrs_pkg::DEF_MAX_WIDTH,
  localparam int unsigned W_MAX    = (MAX_WIDTH < hbrs_pkg::CW_MAX) ? MAX_WIDTH
                                                                     : hbrs_pkg::CW_MAX,
  localparam int unsigned COLS_MAX = ((W_MAX + CHUNK_SIZE - 1) / CHUNK_SIZE) * CHUNK_SIZE,
  localparam int unsigned COLS_W   = $clog2(COLS_MAX + 1)
) (
  input  logic                      clk_i,
  input  logic [hbrs_pkg::CW_W-1:0] chain_width_i,
  output logic [COLS_W-1:0]         cols_o
);
  import hbrs_pkg::*;

  localparam int unsigned NW    = $clog2(W_MAX + CHUNK_SIZE);
  localparam int unsigned SH    = NW + $clog2(CHUNK_SIZE) + 1;
  localparam int unsigned RECIP = ((2 ** SH) + CHUNK_SIZE - 1) / CHUNK_SIZE;
  localparam int unsigned MW    = $clog2(RECIP + 1);
  localparam int unsigned QW    = $clog2((W_MAX + CHUNK_SIZE - 1) / CHUNK_SIZE + 1);
  localparam int unsigned CP_W  = QW + $clog2(CHUNK_SIZE + 1);

  logic [CW_W-1:0]    w_sat;
  logic [NW-1:0]      n;
  logic [NW+MW-1:0]   prod;
  logic [QW-1:0]      q_q, q_d;
  logic [COLS_W-1:0]  cols_q, cols_d;

  assign w_sat  = (chain_width_i > CW_W'(W_MAX)) ? CW_W'(W_MAX) : chain_width_i;
  assign n      = NW'(w_sat) + NW'(CHUNK_SIZE - 1);
  assign prod   = (NW + MW)'(n) * (NW + MW)'(RECIP);
  assign q_d    = QW'(prod >> SH);
  assign cols_d = COLS_W'(CP_W'(q_q) * CP_W'(CHUNK_SIZE));

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    cols_q <= cols_d;
  end

  assign cols_o = cols_q;

endmodule

@@ rtl/hub75_bitplane_row_scheduler_core.sv @@
// Scan scheduler for a row-multiplexed LED matrix with binary-code modulation.
// s_axis carries one request: tuser is the mode (row tick, swap request,
// read-and-clear frames, restart), tdata is the measured timer count.
// m_axis returns one result per request in a 112-bit tdata word; tuser flags
// that the address lines are driven on this tick.
// cfg writes one of six registers by index; they are taken at any time but
// must only change while no request is in flight.
// One request runs through a sequence of steps: two filter steps, a state
// update, three passes of the shared multiplier for the screen-memory
// offset, then an output step that registers the result.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register; if m_axis is stalled, the next request is
// still accepted and its sequence holds in the last step until the output
// register frees up.
// Reset loads the default configuration and the scan state for it: last
// plane of the last row pair, base period five times the chain width.
module hub75_bitplane_row_scheduler_core #(
  parameter int unsigned CHUNK_SIZE = hbrs_pkg::DEF_CHUNK_SIZE,
  parameter int unsigned MAX_WIDTH  = hbrs_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] elapsed
  input  logic [hbrs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [hbrs_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] next_period, [34:32] load_plane, [39:35] load_row,
  // [62:40] byte_offset, [67:63] addr_lines, [72:68] addr_toggle,
  // [73] shown_buffer, [105:74] frames, [106] swap_waiting, [111:107] zero
  output logic [hbrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] addr_update
  output logic [hbrs_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hbrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hbrs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hbrs_pkg::*;

  localparam int unsigned W_MAX    = (MAX_WIDTH < CW_MAX) ? MAX_WIDTH : CW_MAX;
  localparam int unsigned COLS_MAX = ((W_MAX + CHUNK_SIZE - 1) / CHUNK_SIZE) * CHUNK_SIZE;
  localparam int unsigned COLS_W   = $clog2(COLS_MAX + 1);
  localparam int unsigned PROD_W   = COLS_W + IDX_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FLT1 = 8'b0000_0010,
    S_FLT2 = 8'b0000_0100,
    S_UPD  = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_MUL2 = 8'b0010_0000,
    S_MUL3 = 8'b0100_0000,
    S_MUL4 = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [NP_W-1:0]   np_q;
  logic [AL_W-1:0]   al_q;
  logic [CW_W-1:0]   cw_q;
  logic [MINP_W-1:0] minp_q;
  logic              db_q;
  logic [BPE_W-1:0]  bpe_q;

  mode_e              mode_q, mode_d;
  logic [ELAP_W-1:0]  elap_q, elap_d;
  logic [PLANE_W-1:0] prev_q, prev_d;
  logic [FACC_W-1:0]  facc_q, facc_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ROW_W-1:0]   last_q, last_d;
  logic [PER_W-1:0]   bp_q, bp_d;
  logic               buf_q, buf_d;
  logic               swp_q, swp_d;
  logic [FRM_W-1:0]   frm_q, frm_d;
  logic               au_q, au_d;
  logic [ROW_W-1:0]   alines_q, alines_d;
  logic [ROW_W-1:0]   tog_q, tog_d;
  logic [FRM_W-1:0]   fout_q, fout_d;
  logic [PER_W-1:0]   nper_q, nper_d;
  logic [OFF_W-1:0]   acc_q, acc_d;
  logic               ovalid_q, ovalid_d;
  logic               ouser_q, ouser_d;
  res_t               res_q, res_d;

  logic [NP_W-1:0]    planes_eff;
  logic [AL_W-1:0]    lines_eff;
  logic [ROW_W:0]     pairs;
  logic [ROW_W-1:0]   lmask;
  logic [1:0]         bsh;
  logic [PLANE_W-1:0] rs_plane;
  logic [ROW_W-1:0]   rs_row;
  logic [ROW_W-1:0]   rs_last;
  logic               plane_wrap;
  logic               row_wrap;
  logic [PER_W-1:0]   fnew;
  logic [PER_W+7-1:0] per_ext;
  logic [2:0]         buf_sh;
  logic [OFF_W-1:0]   acc_term;
  logic [OFF_W-1:0]   buf_term;
  logic               load_out;

  logic [COLS_W-1:0]  cols;
  logic               mul_en;
  logic [COLS_W-1:0]  mul_a;
  logic [IDX_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;

  hbrs_colpad #(
    .CHUNK_SIZE(CHUNK_SIZE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_colpad (
    .clk_i        (clk_i),
    .chain_width_i(cw_q),
    .cols_o       (cols)
  );

  hbrs_mul #(
    .A_W(COLS_W),
    .B_W(IDX_W)
  ) u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q   <= DEF_NUM_PLANES;
      al_q   <= DEF_ADDR_LINES;
      cw_q   <= DEF_CHAIN;
      minp_q <= DEF_MIN_PERIOD;
      db_q   <= DEF_DBUF;
      bpe_q  <= DEF_BPE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_PLANES: np_q   <= cfg_data_i[NP_W-1:0];
        CFG_ADDR_LINES: al_q   <= cfg_data_i[AL_W-1:0];
        CFG_CHAIN:      cw_q   <= cfg_data_i[CW_W-1:0];
        CFG_MIN_PERIOD: minp_q <= cfg_data_i[MINP_W-1:0];
        CFG_DBUF:       db_q   <= cfg_data_i[0];
        CFG_BPE:        bpe_q  <= cfg_data_i[BPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (np_q == '0) begin
      planes_eff = NP_W'(1);
    end else if (np_q > NP_W'(PLANES_EFF_MAX)) begin
      planes_eff = NP_W'(PLANES_EFF_MAX);
    end else begin
      planes_eff = np_q;
    end
    lines_eff = (al_q > AL_W'(LINES_MAX)) ? AL_W'(LINES_MAX) : al_q;
    pairs     = (ROW_W + 1)'(1) << lines_eff;
    lmask     = ROW_W'(pairs - (ROW_W + 1)'(1));
    if (bpe_q == BPE_W'(1)) begin
      bsh = 2'd0;
    end else if (bpe_q == BPE_W'(2)) begin
      bsh = 2'd1;
    end else begin
      bsh = 2'd2;
    end
    rs_plane   = PLANE_W'(planes_eff - NP_W'(1));
    rs_row     = lmask;
    rs_last    = (pairs > (ROW_W + 1)'(1)) ? ROW_W'(pairs - (ROW_W + 1)'(2)) : ROW_W'(1);
    plane_wrap = ((NP_W'(plane_q) + NP_W'(1)) >= planes_eff);
    row_wrap   = (((ROW_W + 1)'(row_q) + (ROW_W + 1)'(1)) >= pairs);
    fnew       = (facc_q[FACC_W-1:3] < PER_W'(minp_q)) ? PER_W'(minp_q)
                                                       : facc_q[FACC_W-1:3];
    per_ext    = (PER_W + 7)'(bp_q) << prev_q;
    buf_sh     = 3'(lines_eff) + 3'(bsh);
    acc_term   = OFF_W'((PROD_W + 3)'(prod) << bsh);
    buf_term   = (db_q && buf_q) ? OFF_W'((PROD_W + 7)'(prod) << buf_sh) : '0;
  end

  assign load_out = !ovalid_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    elap_d   = elap_q;
    prev_d   = prev_q;
    facc_d   = facc_q;
    plane_d  = plane_q;
    row_d    = row_q;
    last_d   = last_q;
    bp_d     = bp_q;
    buf_d    = buf_q;
    swp_d    = swp_q;
    frm_d    = frm_q;
    au_d     = au_q;
    alines_d = alines_q;
    tog_d    = tog_q;
    fout_d   = fout_q;
    nper_d   = nper_q;
    acc_d    = acc_q;
    ovalid_d = ovalid_q;
    ouser_d  = ouser_q;
    res_d    = res_q;
    mul_en   = 1'b0;
    mul_a    = cols;
    mul_b    = '0;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = mode_e'(s_axis_tuser);
          elap_d  = s_axis_tdata[ELAP_W-1:0];
          prev_d  = plane_q;
          state_d = S_FLT1;
        end
      end
      S_FLT1: begin
        facc_d  = {bp_q, 3'b000} - FACC_W'(bp_q);
        state_d = S_FLT2;
      end
      S_FLT2: begin
        facc_d  = facc_q + FACC_W'(elap_q);
        state_d = S_UPD;
      end
      S_UPD: begin
        au_d     = 1'b0;
        alines_d = '0;
        tog_d    = '0;
        fout_d   = frm_q;
        case (mode_q)
          MODE_TICK: begin
            if (prev_q == PLANE_W'(1) || planes_eff == NP_W'(1)) begin
              bp_d = fnew;
            end
            if (prev_q == '0) begin
              au_d     = 1'b1;
              alines_d = row_q & lmask;
              tog_d    = (row_q ^ last_q) & lmask;
              last_d   = row_q;
            end
            if (plane_wrap) begin
              plane_d = '0;
              if (row_wrap) begin
                row_d = '0;
                if (swp_q) begin
                  buf_d = ~buf_q;
                  swp_d = 1'b0;
                end
                frm_d  = frm_q + FRM_W'(1);
                fout_d = frm_q + FRM_W'(1);
              end else begin
                row_d = row_q + ROW_W'(1);
              end
            end else begin
              plane_d = plane_q + PLANE_W'(1);
            end
          end
          MODE_SWAP: begin
            if (db_q) begin
              swp_d = 1'b1;
            end
          end
          MODE_CLEAR: begin
            frm_d = '0;
          end
          default: begin
            plane_d = rs_plane;
            row_d   = rs_row;
            last_d  = rs_last;
            swp_d   = 1'b0;
            frm_d   = '0;
            fout_d  = '0;
          end
        endcase
        state_d = S_MUL1;
      end
      S_MUL1: begin
        mul_en = 1'b1;
        mul_a  = COLS_W'(planes_eff);
        mul_b  = IDX_W'(row_q);
        if (mode_q == MODE_TICK) begin
          nper_d = (|per_ext[PER_W+7-1:PER_W]) ? '1 : per_ext[PER_W-1:0];
        end else begin
          nper_d = '0;
        end
        state_d = S_MUL2;
      end
      S_MUL2: begin
        mul_en  = 1'b1;
        mul_b   = prod[IDX_W-1:0] + IDX_W'(plane_q);
        state_d = S_MUL3;
      end
      S_MUL3: begin
        mul_en  = 1'b1;
        mul_b   = IDX_W'(planes_eff);
        acc_d   = acc_term;
        state_d = S_MUL4;
      end
      S_MUL4: begin
        if (load_out) begin
          res_d.pad          = '0;
          res_d.swap_waiting = swp_q;
          res_d.frames       = fout_q;
          res_d.shown_buffer = buf_q;
          res_d.addr_toggle  = tog_q;
          res_d.addr_lines   = alines_q;
          res_d.byte_offset  = acc_q + buf_term;
          res_d.load_row     = row_q;
          res_d.load_plane   = plane_q;
          res_d.next_period  = nper_q;
          ouser_d            = au_q;
          ovalid_d           = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      plane_q  <= RST_PLANE;
      row_q    <= RST_ROW;
      last_q   <= RST_LAST;
      bp_q     <= RST_BASE;
      buf_q    <= 1'b0;
      swp_q    <= 1'b0;
      frm_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      plane_q  <= plane_d;
      row_q    <= row_d;
      last_q   <= last_d;
      bp_q     <= bp_d;
      buf_q    <= buf_d;
      swp_q    <= swp_d;
      frm_q    <= frm_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    elap_q   <= elap_d;
    prev_q   <= prev_d;
    facc_q   <= facc_d;
    au_q     <= au_d;
    alines_q <= alines_d;
    tog_q    <= tog_d;
    fout_q   <= fout_d;
    nper_q   <= nper_d;
    acc_q    <= acc_d;
    ouser_q  <= ouser_d;
    res_q    <= res_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = ouser_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while sequence still running");

  a_frames_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_UPD |=> $stable(frm_q) && $stable(buf_q))
    else $error("frame counter or buffer changed outside update step");

  a_addr_fields_need_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      res_q.addr_lines == '0 && res_q.addr_toggle == '0)
    else $error("address fields set without address update");

endmodule
